FILE: rtl/core/qap_pkg.sv
// ----------------------------------------------------------------------------
// qap_pkg
// Shared sizes, codes and command types of the QAP swap local search block.
// ----------------------------------------------------------------------------
`default_nettype none

package qap_pkg;

    // Problem and word sizes
    localparam int MAX_N      = 32;
    localparam int VALUE_BITS = 16;

    localparam int IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;  // unit / location index
    localparam int CNT_W  = $clog2(MAX_N + 1);                // counter that reaches MAX_N
    localparam int LIM_W  = 7;                                // 6-bit fields compared to MAX_N
    localparam int LOC_W  = 6;
    localparam int FA_W   = 2 * IDX_W;                        // matrix address
    localparam int FA_D   = 1 << FA_W;
    localparam int DIF_W  = VALUE_BITS + 1;
    localparam int PROD_W = 2 * DIF_W;
    localparam int ACC_W  = PROD_W + IDX_W + 2;

    localparam logic [LIM_W-1:0] N_LIM       = LIM_W'(MAX_N);
    localparam logic [5:0]       SIZE_RESET  = 6'd32;
    localparam logic [15:0]      PASS_RESET  = 16'd50000;

    // Request codes
    typedef enum logic [1:0] {
        REQ_FLOW = 2'd0,
        REQ_DIST = 2'd1,
        REQ_ASG  = 2'd2,
        REQ_RUN  = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic {
        CFG_PROBLEM_SIZE = 1'b0,
        CFG_MAX_PASSES   = 1'b1
    } t_cfg_idx;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_INIT   = 4'd2,
        OP_CAP    = 4'd3,
        OP_K0     = 4'd4,
        OP_K1     = 4'd5,
        OP_K2     = 4'd6,
        OP_K3     = 4'd7,
        OP_K4     = 4'd8,
        OP_K5     = 4'd9,
        OP_SWAP_I = 4'd10,
        OP_SWAP_J = 4'd11,
        OP_RD_OUT = 4'd12
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] k;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/qap_if.sv
// ----------------------------------------------------------------------------
// qap_in_if / qap_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface qap_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;

    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface qap_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  unit_index;
    logic [5:0]  location;
    logic        last;
    logic [15:0] passes_used;

    modport source (output valid, unit_index, location, last, passes_used, input ready);
    modport sink   (input valid, unit_index, location, last, passes_used, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/qap_ram.sv
// ----------------------------------------------------------------------------
// qap_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_ram #(
    parameter int P_W = 16,
    parameter int P_D = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [$clog2(P_D)-1:0]       i_waddr,
    input  wire  [P_W-1:0]               i_wdata,
    input  wire                          i_re,
    input  wire  [$clog2(P_D)-1:0]       i_raddr_a,
    input  wire  [$clog2(P_D)-1:0]       i_raddr_b,
    output logic [P_W-1:0]               o_rdata_a,
    output logic [P_W-1:0]               o_rdata_b
);

    logic [P_W-1:0] r_mem [P_D];

    // Write, and read both ports (a same-address read returns the old data); hold read data when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/qap_ctrl.sv
// ----------------------------------------------------------------------------
// qap_ctrl
// Sequencer: configuration, pass / unit / partner / term loops, don't-look
// bits and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire  [15:0]          i_cfg_data,
    input  wire                  i_in_valid,
    input  wire  [1:0]           i_req_type,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [5:0]           o_unit_index,
    output logic                 o_last,
    output logic [15:0]          o_passes_used,
    input  wire                  i_acc_neg,
    output qap_pkg::t_cmd        o_cmd
);

    localparam int CW = qap_pkg::CNT_W;
    localparam int IW = qap_pkg::IDX_W;

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_PASS   = 15'h0002,
        S_ICHK   = 15'h0004,
        S_JCHK   = 15'h0008,
        S_CAP    = 15'h0010,
        S_KCHK   = 15'h0020,
        S_K1     = 15'h0040,
        S_K2     = 15'h0080,
        S_K3     = 15'h0100,
        S_K4     = 15'h0200,
        S_K5     = 15'h0400,
        S_DECIDE = 15'h0800,
        S_SWAP   = 15'h1000,
        S_ORD    = 15'h2000,
        S_OVLD   = 15'h4000
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_i, n_i, r_j, n_j, r_k, n_k, r_n, n_n;
    logic [15:0]               r_passes, n_passes;
    logic                      r_improved, n_improved;
    logic [qap_pkg::MAX_N-1:0] r_dl, n_dl;
    logic [5:0]                r_size;
    logic [15:0]               r_maxp;
    qap_pkg::t_op              op;
    logic [qap_pkg::LIM_W-1:0] size_ext;

    assign size_ext = qap_pkg::LIM_W'(r_size);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= qap_pkg::SIZE_RESET;
            r_maxp <= qap_pkg::PASS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qap_pkg::CFG_PROBLEM_SIZE: r_size <= i_cfg_data[5:0];
                qap_pkg::CFG_MAX_PASSES:   r_maxp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and loop counters
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_n        = r_n;
        n_passes   = r_passes;
        n_improved = r_improved;
        n_dl       = r_dl;
        op         = qap_pkg::OP_NONE;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == qap_pkg::REQ_RUN) begin
                        n_n        = (size_ext > qap_pkg::N_LIM) ? CW'(qap_pkg::MAX_N)
                                                                 : CW'(r_size);
                        n_passes   = '0;
                        n_improved = 1'b1;
                        n_dl       = '0;
                        n_state    = S_PASS;
                    end else begin
                        op = qap_pkg::OP_LOAD;
                    end
                end
            end
            S_PASS: begin
                if (r_passes < r_maxp && r_improved) begin
                    n_passes   = r_passes + 16'd1;
                    n_improved = 1'b0;
                    n_i        = '0;
                    n_state    = S_ICHK;
                end else if (r_n == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = '0;
                    n_state = S_ORD;
                end
            end
            S_ICHK: begin
                if (r_i >= r_n) begin
                    n_state = S_PASS;
                end else if (r_dl[r_i[IW-1:0]]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j     = '0;
                    n_state = S_JCHK;
                end
            end
            S_JCHK: begin
                if (r_j >= r_n) begin
                    n_dl[r_i[IW-1:0]] = 1'b1;
                    n_i     = r_i + CW'(1);
                    n_state = S_ICHK;
                end else if (r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end else begin
                    op      = qap_pkg::OP_INIT;
                    n_k     = '0;
                    n_state = S_CAP;
                end
            end
            S_CAP: begin
                op      = qap_pkg::OP_CAP;
                n_state = S_KCHK;
            end
            S_KCHK: begin
                if (r_k >= r_n) begin
                    n_state = S_DECIDE;
                end else if (r_k == r_i || r_k == r_j) begin
                    n_k = r_k + CW'(1);
                end else begin
                    op      = qap_pkg::OP_K0;
                    n_state = S_K1;
                end
            end
            S_K1: begin
                op      = qap_pkg::OP_K1;
                n_state = S_K2;
            end
            S_K2: begin
                op      = qap_pkg::OP_K2;
                n_state = S_K3;
            end
            S_K3: begin
                op      = qap_pkg::OP_K3;
                n_state = S_K4;
            end
            S_K4: begin
                op      = qap_pkg::OP_K4;
                n_state = S_K5;
            end
            S_K5: begin
                op      = qap_pkg::OP_K5;
                n_k     = r_k + CW'(1);
                n_state = S_KCHK;
            end
            S_DECIDE: begin
                if (i_acc_neg) begin
                    op = qap_pkg::OP_SWAP_I;
                    n_dl[r_j[IW-1:0]] = 1'b0;
                    n_improved = 1'b1;
                    n_state    = S_SWAP;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_JCHK;
                end
            end
            S_SWAP: begin
                op      = qap_pkg::OP_SWAP_J;
                n_state = S_PASS;
            end
            S_ORD: begin
                op      = qap_pkg::OP_RD_OUT;
                n_state = S_OVLD;
            end
            S_OVLD: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_passes   <= '0;
            r_improved <= 1'b0;
            r_dl       <= '0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_n        <= n_n;
            r_passes   <= n_passes;
            r_improved <= n_improved;
            r_dl       <= n_dl;
        end
    end

    // Command and result fields
    assign o_cmd.op       = op;
    assign o_cmd.i        = r_i;
    assign o_cmd.j        = r_j;
    assign o_cmd.k        = r_k;
    assign o_unit_index   = 6'(r_k);
    assign o_last         = ((CW+1)'(r_k) + (CW+1)'(1)) == (CW+1)'(r_n);
    assign o_passes_used  = r_passes;

endmodule

`default_nettype wire

FILE: rtl/core/qap_dp.sv
// ----------------------------------------------------------------------------
// qap_dp
// Datapath: flow, distance and assignment memories, term operands,
// shared multiplier and swap-difference accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_dp (
    input  wire                 i_clk,
    input  qap_pkg::t_cmd       i_cmd,
    input  wire  [1:0]          i_req_type,
    input  wire  [5:0]          i_row,
    input  wire  [5:0]          i_col,
    input  wire  [15:0]         i_value,
    output logic                o_acc_neg,
    output logic [5:0]          o_location
);

    localparam int IW = qap_pkg::IDX_W;
    localparam int VW = qap_pkg::VALUE_BITS;
    localparam int DW = qap_pkg::DIF_W;
    localparam int PW = qap_pkg::PROD_W;
    localparam int AW = qap_pkg::ACC_W;
    localparam int LW = qap_pkg::LIM_W;

    logic                   fl_we, ds_we, as_we, fl_re, ds_re, as_re;
    logic [qap_pkg::FA_W-1:0] fl_wa, fl_ra, fl_rb, ds_ra, ds_rb;
    logic [IW-1:0]          as_wa, as_ra, as_rb;
    logic [5:0]             as_wd;
    logic [VW-1:0]          wword, fl_qa, fl_qb, ds_qa, ds_qb;
    logic [5:0]             as_qa, as_qb;
    logic                   in_row_ok, in_col_ok;
    logic [IW-1:0]          ii, jj, kk;

    logic [5:0]             r_lr, r_ls, r_lk;
    logic [VW-1:0]          r_frk, r_fsk, r_fkr, r_fks, r_d1, r_d2, r_d3, r_d4;
    logic                   r_oka, r_okb;
    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;
    logic signed [DW-1:0]   mul_a, mul_b;

    assign ii        = i_cmd.i[IW-1:0];
    assign jj        = i_cmd.j[IW-1:0];
    assign kk        = i_cmd.k[IW-1:0];
    assign wword     = VW'(i_value);
    assign in_row_ok = LW'(i_row) < qap_pkg::N_LIM;
    assign in_col_ok = LW'(i_col) < qap_pkg::N_LIM;

    function automatic logic loc_ok(input logic [5:0] a, input logic [5:0] b);
        loc_ok = (LW'(a) < qap_pkg::N_LIM) && (LW'(b) < qap_pkg::N_LIM);
    endfunction

    function automatic logic signed [DW-1:0] diff(input logic [VW-1:0] a,
                                                  input logic [VW-1:0] b);
        diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // Memory port control per operation
    always_comb begin
        fl_we = 1'b0; ds_we = 1'b0; as_we = 1'b0;
        fl_re = 1'b0; ds_re = 1'b0; as_re = 1'b0;
        fl_wa = {i_row[IW-1:0], i_col[IW-1:0]};
        fl_ra = '0; fl_rb = '0; ds_ra = '0; ds_rb = '0;
        as_wa = i_row[IW-1:0];
        as_wd = i_value[5:0];
        as_ra = kk;
        as_rb = jj;
        case (i_cmd.op)
            qap_pkg::OP_LOAD: begin
                fl_we = (i_req_type == qap_pkg::REQ_FLOW) && in_row_ok && in_col_ok;
                ds_we = (i_req_type == qap_pkg::REQ_DIST) && in_row_ok && in_col_ok;
                as_we = (i_req_type == qap_pkg::REQ_ASG) && in_row_ok;
            end
            qap_pkg::OP_INIT: begin
                as_re = 1'b1;
                as_ra = ii;
            end
            qap_pkg::OP_K0: begin
                as_re = 1'b1;
                fl_re = 1'b1;
                fl_ra = {ii, kk};
                fl_rb = {jj, kk};
            end
            qap_pkg::OP_K1: begin
                fl_re = 1'b1;
                fl_ra = {kk, ii};
                fl_rb = {kk, jj};
                ds_re = 1'b1;
                ds_ra = {r_ls[IW-1:0], as_qa[IW-1:0]};
                ds_rb = {r_lr[IW-1:0], as_qa[IW-1:0]};
            end
            qap_pkg::OP_K2: begin
                ds_re = 1'b1;
                ds_ra = {r_lk[IW-1:0], r_ls[IW-1:0]};
                ds_rb = {r_lk[IW-1:0], r_lr[IW-1:0]};
            end
            qap_pkg::OP_SWAP_I: begin
                as_we = 1'b1;
                as_wa = ii;
                as_wd = r_ls;
            end
            qap_pkg::OP_SWAP_J: begin
                as_we = 1'b1;
                as_wa = jj;
                as_wd = r_lr;
            end
            qap_pkg::OP_RD_OUT: begin
                as_re = 1'b1;
            end
            default: ;
        endcase
    end

    qap_ram #(.P_W(VW), .P_D(qap_pkg::FA_D)) u_flow (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_wa), .i_wdata(wword),
        .i_re(fl_re), .i_raddr_a(fl_ra), .i_raddr_b(fl_rb),
        .o_rdata_a(fl_qa), .o_rdata_b(fl_qb)
    );

    qap_ram #(.P_W(VW), .P_D(qap_pkg::FA_D)) u_dist (
        .i_clk(i_clk), .i_we(ds_we), .i_waddr(fl_wa), .i_wdata(wword),
        .i_re(ds_re), .i_raddr_a(ds_ra), .i_raddr_b(ds_rb),
        .o_rdata_a(ds_qa), .o_rdata_b(ds_qb)
    );

    qap_ram #(.P_W(6), .P_D(1 << IW)) u_asg (
        .i_clk(i_clk), .i_we(as_we), .i_waddr(as_wa), .i_wdata(as_wd),
        .i_re(as_re), .i_raddr_a(as_ra), .i_raddr_b(as_rb),
        .o_rdata_a(as_qa), .o_rdata_b(as_qb)
    );

    // Select multiplier operands for the two terms of one k
    always_comb begin
        if (i_cmd.op == qap_pkg::OP_K3) begin
            mul_a = diff(r_frk, r_fsk);
            mul_b = diff(r_d1, r_d2);
        end else begin
            mul_a = diff(r_fkr, r_fks);
            mul_b = diff(r_d3, r_d4);
        end
    end

    // Capture operands, multiply, accumulate
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            qap_pkg::OP_INIT: r_acc <= '0;
            qap_pkg::OP_CAP: begin
                r_lr <= as_qa;
                r_ls <= as_qb;
            end
            qap_pkg::OP_K1: begin
                r_lk  <= as_qa;
                r_frk <= fl_qa;
                r_fsk <= fl_qb;
                r_oka <= loc_ok(r_ls, as_qa);
                r_okb <= loc_ok(r_lr, as_qa);
            end
            qap_pkg::OP_K2: begin
                r_fkr <= fl_qa;
                r_fks <= fl_qb;
                r_d1  <= r_oka ? ds_qa : '0;
                r_d2  <= r_okb ? ds_qb : '0;
                r_oka <= loc_ok(r_lk, r_ls);
                r_okb <= loc_ok(r_lk, r_lr);
            end
            qap_pkg::OP_K3: begin
                r_d3   <= r_oka ? ds_qa : '0;
                r_d4   <= r_okb ? ds_qb : '0;
                r_prod <= mul_a * mul_b;
            end
            qap_pkg::OP_K4: begin
                r_acc  <= r_acc + AW'(r_prod);
                r_prod <= mul_a * mul_b;
            end
            qap_pkg::OP_K5: r_acc <= r_acc + AW'(r_prod);
            default: ;
        endcase
    end

    assign o_acc_neg  = r_acc[AW-1];
    assign o_location = as_qa;

endmodule

`default_nettype wire

FILE: rtl/core/qap_swap_local_search.sv
// ----------------------------------------------------------------------------
// qap_swap_local_search
// Pairwise-swap local search for the quadratic assignment problem.
// ----------------------------------------------------------------------------
// Load beats (flow word, distance word, assignment entry) are accepted back to
// back while idle. A run beat clears the don't-look bits and performs improvement
// passes; each swap difference steps through operations K0 to K5 for every term
// unit k and passes over each skipped k, paced by the single-read-pair flow and
// distance memories and the one shared multiplier. A run then returns one result
// beat per unit in use (problem_size, capped at 32), each held until the sink is
// ready. No request is taken during a run or its results.
// Memories start undefined; every entry a run touches must be loaded first.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_swap_local_search (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire  [15:0]  i_cfg_data,
    qap_in_if.sink       i_req,
    qap_out_if.source    o_res
);

    qap_pkg::t_cmd cmd;
    logic          acc_neg;

    qap_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_req.valid),
        .i_req_type    (i_req.req_type),
        .o_in_ready    (i_req.ready),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_unit_index  (o_res.unit_index),
        .o_last        (o_res.last),
        .o_passes_used (o_res.passes_used),
        .i_acc_neg     (acc_neg),
        .o_cmd         (cmd)
    );

    qap_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_req_type (i_req.req_type),
        .i_row      (i_req.row),
        .i_col      (i_req.col),
        .i_value    (i_req.value),
        .o_acc_neg  (acc_neg),
        .o_location (o_res.location)
    );

endmodule

`default_nettype wire

FILE: rtl/core/qap_checker.sv
// ----------------------------------------------------------------------------
// qap_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [5:0]  i_unit_index,
    input wire        i_last,
    input wire [15:0] i_passes_used
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // No request taken while results are pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request ready during result stream");

    // Close the stream after the last beat
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last |=> !i_out_valid)
        else $error("beat after last");

    // Advance the unit by one and keep the pass count
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |-> ##2
        (i_out_valid && i_unit_index == 6'($past(i_unit_index, 2) + 6'd1)
         && i_passes_used == $past(i_passes_used, 2)))
        else $error("result sequence broken");

endmodule

bind qap_swap_local_search qap_checker u_qap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_unit_index  (o_res.unit_index),
    .i_last        (o_res.last),
    .i_passes_used (o_res.passes_used)
);

`default_nettype wire

FILE: tb/sv/qap_swap_local_search_checker.sv
// ----------------------------------------------------------------------------
// qap_swap_local_search_checker
// Watches the request, result and configuration ports of the QAP swap search
// block, keeps its own copy of the stores, predicts each run's assignment
// beats and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_swap_local_search_checker
    import qap_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire  [15:0]  i_cfg_data,
    qap_in_if            i_req,
    qap_out_if           i_res,
    output int           o_pending,
    output int           o_fail_cnt
);

    typedef struct {
        logic [5:0]  unit_index;
        logic [5:0]  location;
        logic        last;
        logic [15:0] passes_used;
    } t_asg_beat;

    logic [VALUE_BITS-1:0] flow_mem [MAX_N][MAX_N];
    logic [VALUE_BITS-1:0] dist_mem [MAX_N][MAX_N];
    logic [5:0]            place    [MAX_N];
    bit                    skip_unit[MAX_N];
    logic [5:0]            size_reg;
    logic [15:0]           pass_limit;
    t_asg_beat             asg_q[$];
    int                    fail_cnt;

    assign o_pending  = asg_q.size();
    assign o_fail_cnt = fail_cnt;

    function automatic longint dist_rd(logic [5:0] a, logic [5:0] b);
        if (a >= MAX_N || b >= MAX_N)
            return 0;
        return longint'(dist_mem[a][b]);
    endfunction

    // Factorized cost change of exchanging the locations of units r and s
    function automatic longint swap_gain(int n, int r, int s);
        longint acc;
        logic [5:0] lr, ls, lk;
        acc = 0;
        lr = place[r];
        ls = place[s];
        for (int k = 0; k < n; k++) begin
            if (k == r || k == s)
                continue;
            lk = place[k];
            acc += (longint'(flow_mem[r][k]) - longint'(flow_mem[s][k]))
                   * (dist_rd(ls, lk) - dist_rd(lr, lk));
            acc += (longint'(flow_mem[k][r]) - longint'(flow_mem[k][s]))
                   * (dist_rd(lk, ls) - dist_rd(lk, lr));
        end
        return acc;
    endfunction

    // One first-improvement scan; returns 1 when a swap was taken
    function automatic bit improve_pass(int n);
        logic [5:0] t;
        for (int i = 0; i < n; i++) begin
            if (skip_unit[i])
                continue;
            for (int j = 0; j < n; j++) begin
                if (j == i)
                    continue;
                if (swap_gain(n, i, j) < 0) begin
                    t = place[i];
                    place[i] = place[j];
                    place[j] = t;
                    skip_unit[j] = 0;
                    return 1;
                end
            end
            skip_unit[i] = 1;
        end
        return 0;
    endfunction

    // Search to a local optimum and queue the assignment beats
    task automatic predict_search();
        int n;
        int passes;
        bit moved;
        t_asg_beat b;
        n = (size_reg > MAX_N) ? MAX_N : int'(size_reg);
        passes = 0;
        moved = 1;
        for (int u = 0; u < MAX_N; u++)
            skip_unit[u] = 0;
        while (passes < int'(pass_limit) && moved) begin
            moved = improve_pass(n);
            passes++;
        end
        for (int u = 0; u < n; u++) begin
            b.unit_index  = 6'(u);
            b.location    = place[u];
            b.last        = (u + 1 == n);
            b.passes_used = 16'(passes);
            asg_q.insert(asg_q.size(), b);
        end
    endtask

    always @(posedge i_clk) begin
        t_asg_beat want;
        if (!i_rst_n) begin
            size_reg   <= SIZE_RESET;
            pass_limit <= PASS_RESET;
            fail_cnt   = 0;
            asg_q.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PROBLEM_SIZE)
                    size_reg <= i_cfg_data[5:0];
                else
                    pass_limit <= i_cfg_data;
            end
            // Request beats update the mirror or start a prediction
            if (i_req.valid && i_req.ready) begin
                case (t_req'(i_req.req_type))
                    REQ_FLOW: begin
                        if (i_req.row < MAX_N && i_req.col < MAX_N)
                            flow_mem[i_req.row][i_req.col] = i_req.value;
                    end
                    REQ_DIST: begin
                        if (i_req.row < MAX_N && i_req.col < MAX_N)
                            dist_mem[i_req.row][i_req.col] = i_req.value;
                    end
                    REQ_ASG: begin
                        if (i_req.row < MAX_N)
                            place[i_req.row] = i_req.value[5:0];
                    end
                    REQ_RUN: predict_search();
                endcase
            end
            // Compare result beats against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (asg_q.size() == 0) begin
                    $error("unexpected result beat: unit_index %0d", i_res.unit_index);
                    fail_cnt++;
                end else begin
                    want = asg_q.pop_front();
                    if (i_res.unit_index !== want.unit_index) begin
                        $error("unit_index: expected %0d, got %0d",
                               want.unit_index, i_res.unit_index);
                        fail_cnt++;
                    end
                    if (i_res.location !== want.location) begin
                        $error("location: expected %0d, got %0d",
                               want.location, i_res.location);
                        fail_cnt++;
                    end
                    if (i_res.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_res.last);
                        fail_cnt++;
                    end
                    if (i_res.passes_used !== want.passes_used) begin
                        $error("passes_used: expected %0d, got %0d",
                               want.passes_used, i_res.passes_used);
                        fail_cnt++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/qap_swap_local_search_tb.sv
// ----------------------------------------------------------------------------
// qap_swap_local_search_tb
// Fills the corner of both matrices that small runs touch and the whole
// assignment, then runs directed searches over the size and pass-limit
// extremes and random load/run traffic under several idle and stall patterns.
// The checker predicts and compares every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module qap_swap_local_search_tb;
    import qap_pkg::*;

    // Matrix corner loaded up front; runs that search stay within it
    localparam int FILL_N = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          pending;
    int          fail_cnt;
    int          gap_pct;
    int          stall_pct;

    qap_in_if  req_if();
    qap_out_if res_if();

    qap_swap_local_search DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    qap_swap_local_search_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .i_res      (res_if),
        .o_pending  (pending),
        .o_fail_cnt (fail_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Guard against a hung run
    initial begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Location inside the loaded corner, or now and then one past the table (32 to 63)
    function automatic logic [5:0] pick_loc();
        return ($urandom_range(9) == 0) ? 6'($urandom_range(63, 32))
                                        : 6'($urandom_range(FILL_N - 1));
    endfunction

    // Drive one request beat and hold it until accepted
    task automatic send_req(t_req req, logic [5:0] row, logic [5:0] col,
                            logic [15:0] val);
        while ($urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= req;
        req_if.row      <= row;
        req_if.col      <= col;
        req_if.value    <= val;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    // Write a register once the block has drained
    task automatic write_cfg(t_cfg_idx idx, logic [15:0] data);
        req_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_search(logic [15:0] n, logic [15:0] limit);
        write_cfg(CFG_PROBLEM_SIZE, n);
        write_cfg(CFG_MAX_PASSES, limit);
    endtask

    // Random load and run traffic over a small problem
    task automatic random_burst(int count);
        int roll;
        logic [15:0] lim;
        for (int t = 0; t < count; t++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                lim = ($urandom_range(1)) ? 16'($urandom_range(65535, 1))
                                           : 16'($urandom_range(4, 1));
                set_search(16'($urandom_range(6, 2)), lim);
            end else if (roll < 20)
                send_req(REQ_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
            else if (roll < 28)
                send_req(t_req'($urandom_range(2)), 6'($urandom_range(63, 32)),
                         6'($urandom), 16'($urandom));
            else if (roll < 48)
                send_req(REQ_ASG, 6'($urandom_range(7)), 6'($urandom),
                         {10'($urandom), pick_loc()});
            else
                send_req(t_req'($urandom_range(1)), 6'($urandom_range(7)),
                         6'($urandom_range(7)), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_PROBLEM_SIZE;
        i_cfg_data      = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_FLOW;
        req_if.row      = '0;
        req_if.col      = '0;
        req_if.value    = '0;
        res_if.ready    = 1'b0;
        gap_pct         = 0;
        stall_pct       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the matrix corner and every assignment entry
        for (int r = 0; r < FILL_N; r++) begin
            for (int c = 0; c < FILL_N; c++) begin
                send_req(REQ_FLOW, 6'(r), 6'(c), 16'($urandom));
                send_req(REQ_DIST, 6'(r), 6'(c), 16'($urandom));
            end
        end
        for (int r = 0; r < MAX_N; r++)
            send_req(REQ_ASG, 6'(r), 6'($urandom), {10'($urandom), pick_loc()});

        // Directed: field extremes, ignored loads, size and limit extremes
        send_req(REQ_FLOW, 6'd0, 6'd1, 16'hFFFF);
        send_req(REQ_DIST, 6'd1, 6'd0, 16'h0000);
        send_req(REQ_FLOW, 6'd63, 6'd63, 16'hFFFF);
        send_req(REQ_DIST, 6'd0, 6'd32, 16'hFFFF);
        send_req(REQ_ASG, 6'd40, 6'd0, 16'hFFFF);
        send_req(REQ_ASG, 6'd1, 6'd63, 16'h003F);
        set_search(16'd2, 16'hFFFF);
        send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);
        set_search(16'd1, 16'd3);
        send_req(REQ_RUN, 6'h3F, 6'h3F, 16'hFFFF);
        write_cfg(CFG_PROBLEM_SIZE, 16'd0);
        send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);
        set_search(16'd5, 16'd0);
        send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);
        set_search(16'd32, 16'd0);
        send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);
        set_search(16'd63, 16'd0);
        send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);
        set_search(16'd4, 16'hFFFF);
        send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);

        // Random phases: clean, sender gaps, receiver stalls, both
        for (int p = 0; p < 4; p++) begin
            gap_pct   = (p == 1) ? 53 : (p == 3) ? 10 : 0;
            stall_pct = (p == 2) ? 53 : (p == 3) ? 10 : 0;
            set_search(16'($urandom_range(6, 2)), 16'($urandom_range(65535, 1)));
            random_burst(50);
            send_req(REQ_RUN, 6'd0, 6'd0, 16'h0000);
            req_if.valid <= 1'b0;
        end

        // Drain and give the verdict
        req_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
